/* sv/lsl_pkg.sv */
// ----------------------------------------------------------------------------
// lsl_pkg: shared constants and types for the lattice site locator
// Field widths, register codes, reset values and the pipeline payload types
// used by the divider stages, the mixed radix stages and the top level.
// ----------------------------------------------------------------------------
package lsl_pkg;

	// Lattice geometry
	localparam int DIMS       = 4;
	localparam int COORD_BITS = 12;
	localparam int EXT_BITS   = COORD_BITS + 1;
	localparam int MIN_W      = DIMS * COORD_BITS;
	localparam int EXT_REG_W  = DIMS * EXT_BITS;
	localparam int RANK_W     = 32;

	// Stream payload widths
	localparam int IN_W       = DIMS * COORD_BITS;
	localparam int OUT_DATA_W = 2 * RANK_W;
	localparam int OUT_USER_W = 2;

	// Configuration port
	localparam int CFG_W     = EXT_REG_W;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_LATTICE_SIZES  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_DIVISIONS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_MIN       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_SIZE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EVEN_SITES     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EVEN_FIRST     = 3'd5;

	localparam logic [EXT_REG_W-1:0] RST_LATTICE_SIZES  = 52'd4398583447560;
	localparam logic [EXT_REG_W-1:0] RST_NODE_DIVISIONS = 52'd549822930945;
	localparam logic [MIN_W-1:0]     RST_NODE_MIN       = '0;
	localparam logic [EXT_REG_W-1:0] RST_NODE_SIZE      = 52'd4398583447560;
	localparam logic [RANK_W-1:0]    RST_EVEN_SITES     = 32'd2048;
	localparam logic                 RST_EVEN_FIRST     = 1'b1;

	// Pipelined divider: product of coordinate and divisions over lattice extent
	localparam int PROD_W     = COORD_BITS + EXT_BITS;
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = (PROD_W + DIV_STEP - 1) / DIV_STEP;
	localparam int NUM_W      = DIV_STAGES * DIV_STEP;

	// Mixed radix accumulation, one stage per dimension after the slowest
	localparam int MIX_STAGES = DIMS - 1;

	typedef logic [DIMS-1:0][EXT_BITS-1:0] lsl_ext_vec_t;

	// Partial remainder and dividend/quotient shift word of one lane
	typedef struct packed {
		logic [EXT_BITS-1:0] rem;
		logic [NUM_W-1:0]    num;
	} lsl_div_t;

	typedef lsl_div_t [DIMS-1:0] lsl_div_vec_t;

	// Per item side information that rides along the pipeline
	typedef struct packed {
		lsl_ext_vec_t off;
		logic         in_node;
		logic         parity;
	} lsl_side_t;

endpackage

/* sv/lsl_div_stage.sv */
// ----------------------------------------------------------------------------
// lsl_div_stage: one stage of the per dimension restoring divider
// Retires DIV_STEP quotient bits for every dimension lane and registers the
// partial remainder and the dividend/quotient shift word.
// ----------------------------------------------------------------------------
module lsl_div_stage (
	input  logic                 clk,
	input  logic                 en,
	input  lsl_pkg::lsl_ext_vec_t divisor,
	input  lsl_pkg::lsl_div_vec_t din,
	output lsl_pkg::lsl_div_vec_t dout
);
	import lsl_pkg::*;

	lsl_div_vec_t nxt;

	// Per step: shift in one dividend bit, subtract when it fits, shift in the quotient bit
	function automatic lsl_div_t div_steps(lsl_div_t cur, logic [EXT_BITS-1:0] dv);
		logic [EXT_BITS:0] trial;
		lsl_div_t          acc;
		acc = cur;
		for (int i = 0; i < DIV_STEP; i++) begin
			trial = {acc.rem, acc.num[NUM_W-1]};
			if (trial >= {1'b0, dv}) begin
				acc.rem = EXT_BITS'(trial - {1'b0, dv});
				acc.num = {acc.num[NUM_W-2:0], 1'b1};
			end else begin
				acc.rem = trial[EXT_BITS-1:0];
				acc.num = {acc.num[NUM_W-2:0], 1'b0};
			end
		end
		return acc;
	endfunction

	// Work all lanes in parallel
	always_comb begin
		for (int d = 0; d < DIMS; d++) begin
			nxt[d] = div_steps(din[d], divisor[d]);
		end
	end

	// Advance on pipeline enable
	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

/* sv/lsl_mix_stage.sv */
// ----------------------------------------------------------------------------
// lsl_mix_stage: one mixed radix step for owner rank and local run index
// Multiplies both accumulators by the radix of the next faster dimension,
// adds that dimension's digit and offset, and registers the results.
// ----------------------------------------------------------------------------
module lsl_mix_stage (
	input  logic                         clk,
	input  logic                         en,
	input  logic [lsl_pkg::RANK_W-1:0]   rank_i,
	input  logic [lsl_pkg::RANK_W-1:0]   run_i,
	input  logic [lsl_pkg::EXT_BITS-1:0] radix_div,
	input  logic [lsl_pkg::EXT_BITS-1:0] radix_size,
	input  logic [lsl_pkg::RANK_W-1:0]   digit,
	input  logic [lsl_pkg::EXT_BITS-1:0] off,
	output logic [lsl_pkg::RANK_W-1:0]   rank_o,
	output logic [lsl_pkg::RANK_W-1:0]   run_o
);
	import lsl_pkg::*;

	logic [RANK_W-1:0] rank_nxt;
	logic [RANK_W-1:0] run_nxt;

	// Horner step, wrapping modulo 2^32
	assign rank_nxt = rank_i * RANK_W'(radix_div) + digit;
	assign run_nxt  = run_i * RANK_W'(radix_size) + RANK_W'(off);

	// Advance on pipeline enable
	always_ff @(posedge clk) begin
		if (en) begin
			rank_o <= rank_nxt;
			run_o  <= run_nxt;
		end
	end

endmodule

/* sv/lattice_site_locator_unit.sv */
// ----------------------------------------------------------------------------
// lattice_site_locator_unit: block domain decomposition site locator
// Maps a four dimensional global lattice coordinate to its owning node rank,
// an on-node flag, the local site index and the site parity.
// Usage:
//   Input channel s_*: one coordinate item per handshake, x in the low bits.
//   Output channel m_*: one result item per input item, in order.
//   Config port cfg_*: write registers by index while the block is idle;
//   a write takes effect at the clock edge where cfg_wr_en is high.
// Pipeline and throughput:
//   Twelve register stages: one multiply stage, seven divider stages retiring
//   four quotient bits each, three mixed radix stages and the output register.
//   One item per cycle while not stalled; every stage is a pipeline register.
// Reset: arst_n clears all valid bits and loads the default geometry
//   (extents 8, one division per dimension, box at origin, even-first order).
// Stall: when m_tready is low with a result held, the whole pipeline freezes
//   and s_tready drops; no item is lost or repeated.
// ----------------------------------------------------------------------------
module lattice_site_locator_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input item
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lsl_pkg::IN_W-1:0]        s_tdata,  // coord_x, coord_y, coord_z, coord_t
	// Result item
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lsl_pkg::OUT_DATA_W-1:0]  m_tdata,  // owner_rank, local_index
	output logic [lsl_pkg::OUT_USER_W-1:0]  m_tuser,  // on_node, site_parity
	// Configuration writes
	input  logic                            cfg_wr_en,
	input  logic [lsl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lsl_pkg::CFG_W-1:0]       cfg_wdata
);
	import lsl_pkg::*;

	localparam int DIV_END = DIV_STAGES + 1;
	localparam int MIX_END = DIV_END + MIX_STAGES;

	// Configuration registers
	logic [EXT_REG_W-1:0] lattice_sizes_q;
	logic [EXT_REG_W-1:0] node_divisions_q;
	logic [MIN_W-1:0]     node_min_q;
	logic [EXT_REG_W-1:0] node_size_q;
	logic [RANK_W-1:0]    even_sites_q;
	logic                 even_first_q;

	// Unpacked per dimension views
	lsl_ext_vec_t                       ls;
	lsl_ext_vec_t                       nd;
	lsl_ext_vec_t                       sz;
	logic [DIMS-1:0][COORD_BITS-1:0]    mn;
	logic [DIMS-1:0][COORD_BITS-1:0]    crd;
	logic [DIMS-1:0][PROD_W-1:0]        prod;
	logic [DIMS-1:0]                    in_box;

	// Pipeline
	logic                 adv;
	logic [MIX_END:1]     valid_s;
	lsl_div_vec_t         div_in;
	lsl_side_t            side_in;
	lsl_div_vec_t         div_s [1:DIV_END];
	lsl_side_t            side_s [1:MIX_END];
	logic [DIMS-1:0][RANK_W-1:0] dig_head;
	logic [DIMS-1:0][RANK_W-1:0] dig_s [DIV_END+1:MIX_END-1];
	logic [RANK_W-1:0]    rank_s [DIV_END+1:MIX_END];
	logic [RANK_W-1:0]    run_s [DIV_END+1:MIX_END];
	logic [RANK_W-1:0]    idx;

	// Write configuration registers, ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lattice_sizes_q  <= RST_LATTICE_SIZES;
			node_divisions_q <= RST_NODE_DIVISIONS;
			node_min_q       <= RST_NODE_MIN;
			node_size_q      <= RST_NODE_SIZE;
			even_sites_q     <= RST_EVEN_SITES;
			even_first_q     <= RST_EVEN_FIRST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LATTICE_SIZES:  lattice_sizes_q  <= cfg_wdata[EXT_REG_W-1:0];
				REG_NODE_DIVISIONS: node_divisions_q <= cfg_wdata[EXT_REG_W-1:0];
				REG_NODE_MIN:       node_min_q       <= cfg_wdata[MIN_W-1:0];
				REG_NODE_SIZE:      node_size_q      <= cfg_wdata[EXT_REG_W-1:0];
				REG_EVEN_SITES:     even_sites_q     <= cfg_wdata[RANK_W-1:0];
				REG_EVEN_FIRST:     even_first_q     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Split packed registers and input coordinates per dimension
	always_comb begin
		for (int d = 0; d < DIMS; d++) begin
			ls[d]  = lattice_sizes_q[d*EXT_BITS +: EXT_BITS];
			nd[d]  = node_divisions_q[d*EXT_BITS +: EXT_BITS];
			sz[d]  = node_size_q[d*EXT_BITS +: EXT_BITS];
			mn[d]  = node_min_q[d*COORD_BITS +: COORD_BITS];
			crd[d] = s_tdata[d*COORD_BITS +: COORD_BITS];
		end
	end

	// Hold everything while a result waits downstream
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// Stage 1: products, box offsets, box test and parity
	always_comb begin
		side_in.parity = 1'b0;
		for (int d = 0; d < DIMS; d++) begin
			prod[d]          = PROD_W'(crd[d]) * PROD_W'(nd[d]);
			div_in[d].rem    = '0;
			div_in[d].num    = NUM_W'(prod[d]);
			side_in.off[d]   = {1'b0, crd[d]} - {1'b0, mn[d]};
			in_box[d]        = (crd[d] >= mn[d]) && (side_in.off[d] < sz[d]);
			side_in.parity   = side_in.parity ^ crd[d][0];
		end
		side_in.in_node = &in_box;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[1] <= div_in;
		end
	end

	// Valid bits travel with the items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s  <= '0;
			m_tvalid <= 1'b0;
		end else if (adv) begin
			valid_s  <= {valid_s[MIX_END-1:1], s_tvalid};
			m_tvalid <= valid_s[MIX_END];
		end
	end

	// Side information shift line
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[1] <= side_in;
			for (int i = 2; i <= MIX_END; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// Divider stages
	for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
		lsl_div_stage u_div (
			.clk     (clk),
			.en      (adv),
			.divisor (ls),
			.din     (div_s[g]),
			.dout    (div_s[g+1])
		);
	end

	// Node digits; a zero lattice extent gives digit zero
	always_comb begin
		for (int d = 0; d < DIMS; d++) begin
			dig_head[d] = (ls[d] == '0) ? '0 : RANK_W'(div_s[DIV_END][d].num);
		end
	end

	// Carry digits still needed by later mixed radix stages
	always_ff @(posedge clk) begin
		if (adv) begin
			dig_s[DIV_END+1] <= dig_head;
			for (int i = DIV_END + 2; i <= MIX_END - 1; i++) begin
				dig_s[i] <= dig_s[i-1];
			end
		end
	end

	// Mixed radix stages, slowest dimension first
	for (genvar g = 0; g < MIX_STAGES; g++) begin : g_mix
		localparam int D = DIMS - 2 - g;
		localparam int I = DIV_END + g;
		logic [RANK_W-1:0] rank_in;
		logic [RANK_W-1:0] run_in;
		logic [RANK_W-1:0] dig;
		if (g == 0) begin : g_head
			assign rank_in = dig_head[DIMS-1];
			assign run_in  = RANK_W'(side_s[I].off[DIMS-1]);
			assign dig     = dig_head[D];
		end else begin : g_tail
			assign rank_in = rank_s[I];
			assign run_in  = run_s[I];
			assign dig     = dig_s[I][D];
		end
		lsl_mix_stage u_mix (
			.clk        (clk),
			.en         (adv),
			.rank_i     (rank_in),
			.run_i      (run_in),
			.radix_div  (nd[D]),
			.radix_size (sz[D]),
			.digit      (dig),
			.off        (side_s[I].off[D]),
			.rank_o     (rank_s[I+1]),
			.run_o      (run_s[I+1])
		);
	end

	// Local index: zero off node, even-first halves and offsets odd sites
	always_comb begin
		if (!side_s[MIX_END].in_node) begin
			idx = '0;
		end else if (even_first_q) begin
			idx = (run_s[MIX_END] >> 1)
				+ (side_s[MIX_END].parity ? even_sites_q : '0);
		end else begin
			idx = run_s[MIX_END];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {idx, rank_s[MIX_END]};
			m_tuser <= {side_s[MIX_END].parity, side_s[MIX_END].in_node};
		end
	end

endmodule
